// ----- hw/rtl/b85_pkg.sv -----
// Shared types, constants and the digit-to-character map of the base-85 group encoder.
// No dependencies; every other RTL file imports this package.
`default_nettype none
package b85_pkg;

   localparam int unsigned GroupBytes = 4;
   localparam int unsigned DigitCount = 5;
   localparam int unsigned Radix = 85;
   localparam int unsigned RecipShift = 38;
   // ceil(2**38 / 85): floor(v * RecipMul / 2**38) equals v / 85 for every 32-bit v
   localparam logic [31:0] RecipMul = 32'd3233857729;
   localparam int unsigned QuotWidth = 26;

   typedef logic [6:0] char_type;
   typedef logic [2:0] step_type;

   // One closed group: padded value, index of its last character (1..4) and end flag
   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  last_idx;
      logic        msg_last;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic char_type b85_char(logic [6:0] digit);
      char_type c;
      c = 7'h00;
      if (digit < 7'd10) begin
         c = 7'h30 + digit;
      end else if (digit < 7'd36) begin
         c = 7'h41 + (digit - 7'd10);
      end else if (digit < 7'd62) begin
         c = 7'h61 + (digit - 7'd36);
      end else begin
         unique case (digit)
            7'd62:   c = 7'h21;  // !
            7'd63:   c = 7'h23;  // #
            7'd64:   c = 7'h24;  // $
            7'd65:   c = 7'h25;  // %
            7'd66:   c = 7'h26;  // &
            7'd67:   c = 7'h28;  // (
            7'd68:   c = 7'h29;  // )
            7'd69:   c = 7'h2A;  // *
            7'd70:   c = 7'h2B;  // +
            7'd71:   c = 7'h2D;  // -
            7'd72:   c = 7'h3B;  // ;
            7'd73:   c = 7'h3C;  // <
            7'd74:   c = 7'h3D;  // =
            7'd75:   c = 7'h3E;  // >
            7'd76:   c = 7'h3F;  // ?
            7'd77:   c = 7'h40;  // @
            7'd78:   c = 7'h5E;  // ^
            7'd79:   c = 7'h5F;  // _
            7'd80:   c = 7'h60;  // `
            7'd81:   c = 7'h7B;  // {
            7'd82:   c = 7'h7C;  // |
            7'd83:   c = 7'h7D;  // }
            7'd84:   c = 7'h7E;  // ~
            default: c = 7'h00;
         endcase
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/b85_front.sv -----
// Front end: accepts input bytes, gathers them into groups and closes a group
// on the fourth byte or the message end. Depends on b85_pkg.
`default_nettype none
module b85_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_message_last,
   input  wire b85_pkg::queue_stat_type q_stat,
   output logic                   push_valid,
   output b85_pkg::group_type     push_data
);
   import b85_pkg::*;

   logic [23:0] pending_ff, pending_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        closing;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         count_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

   always_comb begin
      req_ready  = !q_stat.full;
      accept     = req_valid && req_ready;
      closing    = (count_ff == 2'd3) || req_message_last;
      push_valid = accept && closing;
      pending_in = pending_ff;
      count_in   = count_ff;

      // left-align the real bytes, zero padding below
      case (count_ff)
         2'd0:    push_data.value = {req_data_byte, 24'h000000};
         2'd1:    push_data.value = {pending_ff[7:0], req_data_byte, 16'h0000};
         2'd2:    push_data.value = {pending_ff[15:0], req_data_byte, 8'h00};
         default: push_data.value = {pending_ff, req_data_byte};
      endcase
      push_data.last_idx = {1'b0, count_ff} + 3'd1;
      push_data.msg_last = req_message_last;

      if (accept) begin
         if (closing) begin
            pending_in = '0;
            count_in   = '0;
         end else begin
            pending_in = {pending_ff[15:0], req_data_byte};
            count_in   = count_ff + 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/b85_queue.sv -----
// Two-entry queue of closed groups between front end and converter.
// Depends on b85_pkg.
`default_nettype none
module b85_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire b85_pkg::group_type push_data,
   input  wire logic              pop,
   output b85_pkg::queue_stat_type q_stat,
   output b85_pkg::group_type     head
);
   import b85_pkg::*;

   group_type  slot_ff [2];
   group_type  slot_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push;
   logic       do_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_comb begin
      q_stat.full  = (fill_ff == 2'd2);
      q_stat.empty = (fill_ff == 2'd0);
      head         = slot_ff[rd_ptr_ff];
      do_push      = push_valid && !q_stat.full;
      do_pop       = pop && !q_stat.empty;
      slot_in      = slot_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      fill_in      = fill_ff;
      if (do_push) begin
         slot_in[wr_ptr_ff] = push_data;
         wr_ptr_in          = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

endmodule
`default_nettype wire

// ----- hw/rtl/b85_back.sv -----
// Back end: converts one group to five base-85 characters, one digit a cycle
// through a reciprocal multiply, then emits the run. Depends on b85_pkg.
`default_nettype none
module b85_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire b85_pkg::queue_stat_type q_stat,
   input  wire b85_pkg::group_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [6:0]             rsp_char_code,
   output logic                   rsp_run_end,
   output logic                   rsp_message_end
);
   import b85_pkg::*;

   // converter
   logic        busy_ff, busy_in;
   step_type    step_ff, step_in;
   logic [31:0] rem_val_ff, rem_val_in;
   logic [63:0] prod_ff, prod_in;
   char_type    conv_chars_ff [DigitCount];
   char_type    conv_chars_in [DigitCount];
   logic [2:0]  conv_idx_ff, conv_idx_in;
   logic        conv_last_ff, conv_last_in;
   // emitter
   logic        emit_valid_ff, emit_valid_in;
   char_type    out_chars_ff [DigitCount];
   char_type    out_chars_in [DigitCount];
   logic [2:0]  left_ff, left_in;
   logic        out_last_ff, out_last_in;

   logic [QuotWidth-1:0] quot;
   logic [31:0] quot_ext;
   logic [31:0] rem_full;
   logic        accept_rsp;
   logic        emit_free;
   logic        conv_done;
   logic        transfer;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         step_ff       <= '0;
         emit_valid_ff <= 1'b0;
         left_ff       <= '0;
      end else begin
         busy_ff       <= busy_in;
         step_ff       <= step_in;
         emit_valid_ff <= emit_valid_in;
         left_ff       <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_val_ff    <= rem_val_in;
      prod_ff       <= prod_in;
      conv_chars_ff <= conv_chars_in;
      conv_idx_ff   <= conv_idx_in;
      conv_last_ff  <= conv_last_in;
      out_chars_ff  <= out_chars_in;
      out_last_ff   <= out_last_in;
   end

   always_comb begin
      accept_rsp = emit_valid_ff && rsp_ready;
      emit_free  = !emit_valid_ff || (accept_rsp && (left_ff == 3'd0));
      conv_done  = busy_ff && (step_ff == step_type'(DigitCount));
      transfer   = conv_done && emit_free;
      pop        = !q_stat.empty && (!busy_ff || transfer);

      quot     = prod_ff[RecipShift +: QuotWidth];
      quot_ext = {{(32-QuotWidth){1'b0}}, quot};
      rem_full = rem_val_ff - quot_ext * 32'(Radix);

      busy_in       = busy_ff;
      step_in       = step_ff;
      rem_val_in    = rem_val_ff;
      prod_in       = prod_ff;
      conv_chars_in = conv_chars_ff;
      conv_idx_in   = conv_idx_ff;
      conv_last_in  = conv_last_ff;

      if (pop) begin
         busy_in      = 1'b1;
         step_in      = '0;
         rem_val_in   = head.value;
         prod_in      = 64'(head.value) * 64'(RecipMul);
         conv_idx_in  = head.last_idx;
         conv_last_in = head.msg_last;
      end else if (transfer) begin
         busy_in = 1'b0;
      end else if (busy_ff && !conv_done) begin
         // digits come out least significant first; shift them toward the tail
         step_in    = step_ff + 3'd1;
         rem_val_in = quot_ext;
         prod_in    = 64'(quot_ext) * 64'(RecipMul);
         for (int i = DigitCount - 1; i > 0; i--) begin
            conv_chars_in[i] = conv_chars_ff[i-1];
         end
         conv_chars_in[0] = b85_char(rem_full[6:0]);
      end

      emit_valid_in = emit_valid_ff;
      out_chars_in  = out_chars_ff;
      left_in       = left_ff;
      out_last_in   = out_last_ff;
      if (transfer) begin
         emit_valid_in = 1'b1;
         out_chars_in  = conv_chars_ff;
         left_in       = conv_idx_ff;
         out_last_in   = conv_last_ff;
      end else if (accept_rsp) begin
         if (left_ff == 3'd0) begin
            emit_valid_in = 1'b0;
         end else begin
            left_in = left_ff - 3'd1;
         end
         for (int i = 0; i < DigitCount - 1; i++) begin
            out_chars_in[i] = out_chars_ff[i+1];
         end
      end

      rsp_valid       = emit_valid_ff;
      rsp_char_code   = out_chars_ff[0];
      rsp_run_end     = (left_ff == 3'd0);
      rsp_message_end = rsp_run_end && out_last_ff;
   end

`ifndef SYNTHESIS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= step_type'(DigitCount))
      else $error("converter step out of range");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      emit_valid_ff |-> left_ff <= 3'd4 && left_ff != 3'd0 || emit_valid_ff && left_ff == 3'd0)
      else $error("emitter count out of range");

   a_left_count: assert property (@(posedge clock) disable iff (reset)
      emit_valid_ff && rsp_ready && left_ff != 3'd0
      |=> emit_valid_ff && left_ff == $past(left_ff) - 3'd1)
      else $error("emitter skipped or repeated a character");

   a_no_lost_group: assert property (@(posedge clock) disable iff (reset)
      conv_done && !emit_free |=> conv_done)
      else $error("finished group dropped while emitter busy");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/base85_group_encoder.sv -----
// Channel  Handshake            Payload
// req      req_valid/req_ready  req_data_byte[7:0], req_message_last
// rsp      rsp_valid/rsp_ready  rsp_char_code[6:0], rsp_run_end, rsp_message_end
//
// A byte is taken whenever the group queue has room; a closing byte
// also pushes its group. Per group the converter runs a load plus five
// multiply steps by the reciprocal of 85, then hands over to the emitter and
// takes the next waiting group; the emitter sends one character a cycle
// while rsp_ready is high. Synchronous reset clears the pending group and the
// queue. Either side may stall; the two-entry queue decouples them.
// Top level; depends on b85_pkg, b85_front, b85_queue and b85_back.
`default_nettype none
module base85_group_encoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_message_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [6:0]      rsp_char_code,
   output logic            rsp_run_end,
   output logic            rsp_message_end
);
   import b85_pkg::*;

   queue_stat_type q_stat;
   group_type      push_data;
   group_type      head;
   logic           push_valid;
   logic           pop;

   b85_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_message_last (req_message_last),
      .q_stat           (q_stat),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   b85_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .q_stat     (q_stat),
      .head       (head)
   );

   b85_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_code   (rsp_char_code),
      .rsp_run_end     (rsp_run_end),
      .rsp_message_end (rsp_message_end)
   );

endmodule
`default_nettype wire

// ----- test/tb_base85_group_encoder.sv -----
// Self-checking testbench for base85_group_encoder: random byte messages in, base-85 words out.
// Depends only on the RTL top level; the expected character stream is computed here.
`default_nettype none
module tb_base85_group_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned RandomBytes = 480;
   localparam int unsigned DrainCycles = 40;

   typedef struct {
      logic [7:0]  data;
      logic        last;
      int unsigned gap;
      bit          drain;
   } msg_byte_type;

   typedef struct {
      logic [6:0] code;
      logic       run_end;
      logic       message_end;
   } b85_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_message_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [6:0] rsp_char_code;
   logic       rsp_run_end;
   logic       rsp_message_end;

   base85_group_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_message_last (req_message_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_code    (rsp_char_code),
      .rsp_run_end      (rsp_run_end),
      .rsp_message_end  (rsp_message_end)
   );

   msg_byte_type   byte_feed[$];
   b85_char_type   chars_due[$];

   // predictor state: the open group
   logic [23:0] open_group = 24'h0;
   logic [1:0]  open_count = 2'd0;

   int unsigned err_count = 0;
   int unsigned cycle_count = 0;
   int unsigned bytes_taken = 0;
   int unsigned msgs_taken = 0;
   int unsigned chars_seen = 0;
   int unsigned gap_left = 0;
   int unsigned rx_hold = 0;
   bit          gap_armed = 0;
   bit          req_taken = 0;
   bit          tx_calm = 0;
   bit          rx_calm = 0;

   const logic [6:0] punct_chars[23] = '{
      7'h21, 7'h23, 7'h24, 7'h25, 7'h26, 7'h28, 7'h29, 7'h2A, 7'h2B, 7'h2D, 7'h3B, 7'h3C,
      7'h3D, 7'h3E, 7'h3F, 7'h40, 7'h5E, 7'h5F, 7'h60, 7'h7B, 7'h7C, 7'h7D, 7'h7E
   };

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [6:0] digit_glyph(int unsigned d);
      if (d < 10) return 7'(8'h30 + d);
      else if (d < 36) return 7'(8'h41 + d - 10);
      else if (d < 62) return 7'(8'h61 + d - 36);
      return punct_chars[d - 62];
   endfunction

   // Fold one accepted byte into the open group; on close, queue its characters.
   task automatic encode_byte(input logic [7:0] data, input logic last);
      int unsigned nreal;
      logic [31:0] word;
      int unsigned digit[5];
      b85_char_type c;
      if (open_count < 2'd3 && !last) begin
         open_group = {open_group[15:0], data};
         open_count = open_count + 2'd1;
         return;
      end
      nreal = int'(open_count) + 1;
      word = {open_group, data} << (8 * (4 - nreal));
      for (int j = 4; j >= 0; j--) begin
         digit[j] = word % 85;
         word = word / 85;
      end
      for (int n = 0; n <= nreal; n++) begin
         c.code = digit_glyph(digit[n]);
         c.run_end = (n == nreal);
         c.message_end = (n == nreal) && last;
         chars_due.insert(chars_due.size(), c);
      end
      open_group = 24'h0;
      open_count = 2'd0;
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] error: %s", $realtime, what);
      err_count++;
   endtask

   task automatic add_byte(input logic [7:0] data, input logic last, input bit drain = 0);
      msg_byte_type b;
      b.data = data;
      b.last = last;
      b.gap = tx_calm ? 0 : $urandom_range(0, 15);
      b.drain = drain;
      byte_feed.insert(byte_feed.size(), b);
   endtask

   // sender: drive at the falling edge, hold the word until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         req_taken = 0;
         if (!gap_armed && byte_feed.size() != 0) begin
            gap_left = byte_feed[0].gap;
            gap_armed = 1;
         end
         if (gap_armed && byte_feed[0].drain && chars_due.size() != 0) begin
            req_valid <= 1'b0;
         end else if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (gap_armed) begin
            req_valid <= 1'b1;
            req_data_byte <= byte_feed[0].data;
            req_message_last <= byte_feed[0].last;
            void'(byte_feed.pop_front());
            gap_armed = 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (rx_hold != 0) begin
         rsp_ready <= 1'b0;
         rx_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      b85_char_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            encode_byte(req_data_byte, req_message_last);
            req_taken = 1;
            bytes_taken++;
            if (req_message_last) msgs_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            chars_seen++;
            if (chars_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word code=%h", rsp_char_code));
            end else begin
               want = chars_due.pop_front();
               if (rsp_char_code !== want.code)
                  report_mismatch($sformatf("char %0d code %h, want %h",
                                            chars_seen, rsp_char_code, want.code));
               if (rsp_run_end !== want.run_end)
                  report_mismatch($sformatf("char %0d run_end %b, want %b",
                                            chars_seen, rsp_run_end, want.run_end));
               if (rsp_message_end !== want.message_end)
                  report_mismatch($sformatf("char %0d message_end %b, want %b",
                                            chars_seen, rsp_message_end, want.message_end));
            end
            if (chars_seen % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            rx_hold = rx_calm ? 0 : $urandom_range(0, 15);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  chars_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int unsigned queued;
      int unsigned len;
      int unsigned pick;
      logic [7:0]  data;

      // short messages, all-zero and all-one groups, full groups with and without last
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b1);
      add_byte(8'h80, 1'b0); add_byte(8'h01, 1'b0); add_byte(8'h7F, 1'b1);
      add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0); add_byte(8'h55, 1'b0); add_byte(8'hAA, 1'b1);
      add_byte(8'h12, 1'b0); add_byte(8'h34, 1'b0); add_byte(8'h56, 1'b0);
      add_byte(8'h78, 1'b0); add_byte(8'h9A, 1'b1);

      queued = 0;
      while (queued < RandomBytes) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         if (queued % 60 < 8) tx_calm = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 7);
            data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            // drain the pipe at the head of some messages
            add_byte(data, i == len - 1, i == 0 && (queued == 0 || $urandom_range(0, 15) == 0));
            queued++;
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_feed.size() != 0 || req_valid) @(negedge clock);
      while (chars_due.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("encoded %0d bytes in %0d messages into %0d characters", bytes_taken,
               msgs_taken, chars_seen);
      $display("random gaps and stalls on both channels, %0d errors", err_count);
      if (err_count == 0 && chars_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
